// ===== rtl/core/psll_pkg.sv =====
// Shared types, constants and codes for the per-source login lockout block.
// No dependencies; every other file of the block uses this package.
`timescale 1ns / 1ps

package psll_pkg;

	// Table depth default
	localparam int TABLE_ENTRIES_DEF = 8;

	// Field widths
	localparam int ADDR_W      = 32;
	localparam int TIME_W      = 32;
	localparam int COUNT_W     = 8;
	localparam int WAIT_W      = 23;
	localparam int VERDICT_W   = 2;
	localparam int CFG_DATA_W  = 32;
	localparam int CFG_INDEX_W = 2;

	// Register indexes on the configuration port
	localparam logic [CFG_INDEX_W-1:0] REG_AUTH_ENABLED = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_MAX_FAILS    = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_LOCK_MS      = 2'd2;

	// Register reset values
	localparam logic [COUNT_W-1:0] MAX_FAILS_RESET = 8'd5;
	localparam logic [TIME_W-1:0]  LOCK_MS_RESET   = 32'd60000;

	// Wait saturation in whole seconds
	localparam logic [WAIT_W-1:0] WAIT_MAX = 23'd4294967;

	// Millisecond to second conversion
	localparam int MS_PER_S    = 1000;
	localparam int MS_ROUND_UP = 999;

	// Radix-16 divider by a constant: 9 digits of 4 bits cover a 33-bit dividend
	localparam int DIV_IN_W    = TIME_W + 1;
	localparam int DIV_DIGIT_W = 4;
	localparam int DIV_DIGITS  = (DIV_IN_W + DIV_DIGIT_W - 1) / DIV_DIGIT_W;
	localparam int DIV_NUM_W   = DIV_DIGITS * DIV_DIGIT_W;
	localparam int DIV_REM_W   = $clog2(MS_PER_S);
	localparam int DIV_TRIAL_W = DIV_REM_W + 1;

	typedef enum logic [VERDICT_W-1:0] {
		VERDICT_UNCONFIGURED = 2'd0,
		VERDICT_LOCKED       = 2'd1,
		VERDICT_FAILED       = 2'd2,
		VERDICT_ACCEPTED     = 2'd3
	} verdict_t;

	// One source entry of the table
	typedef struct packed {
		logic [ADDR_W-1:0]  addr;
		logic [COUNT_W-1:0] fail_count;
		logic [TIME_W-1:0]  lock_until;
		logic [TIME_W-1:0]  last_fail;
	} entry_t;

	// Controller to datapath
	typedef struct packed {
		logic load;
		logic scan;
		logic decide;
		logic update;
		logic div_start;
		logic emit;
	} psll_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic auth_en;
		logic scan_last;
		logic emit_needed;
		logic div_done;
		logic out_free;
	} psll_status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DECIDE,
		ST_UPDATE,
		ST_DIVGO,
		ST_DIV,
		ST_RESULT
	} state_t;

endpackage

// ===== rtl/core/psll_req_if.sv =====
// Attempt channel: valid/ready handshake carrying one login attempt word.
// Depends on psll_pkg for field widths.
`timescale 1ns / 1ps

interface psll_req_if;
	logic                        valid;
	logic                        ready;
	logic [psll_pkg::ADDR_W-1:0] source_ip;
	logic [psll_pkg::TIME_W-1:0] now_ms;
	logic                        nonce_present;
	logic                        attempt_ok;

	modport source (output valid, output source_ip, output now_ms,
		output nonce_present, output attempt_ok, input ready);
	modport sink (input valid, input source_ip, input now_ms,
		input nonce_present, input attempt_ok, output ready);
endinterface

// ===== rtl/core/psll_rsp_if.sv =====
// Result channel: valid/ready handshake carrying one verdict word.
// Depends on psll_pkg for field widths.
`timescale 1ns / 1ps

interface psll_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [psll_pkg::VERDICT_W-1:0] verdict;
	logic [psll_pkg::WAIT_W-1:0]    wait_seconds;

	modport source (output valid, output verdict, output wait_seconds, input ready);
	modport sink (input valid, input verdict, input wait_seconds, output ready);
endinterface

// ===== rtl/core/psll_div.sv =====
// Iterative divider by the constant 1000, four quotient bits per cycle.
// Depends on psll_pkg for widths and the divisor.
`timescale 1ns / 1ps

module psll_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [psll_pkg::DIV_IN_W-1:0]  dividend,
	output logic                           done,
	output logic [psll_pkg::DIV_NUM_W-1:0] quotient
);
	import psll_pkg::*;

	localparam int CNT_W = (DIV_DIGITS > 1) ? $clog2(DIV_DIGITS) : 1;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_DIGITS - 1);
	localparam logic [DIV_TRIAL_W-1:0] DIVISOR = DIV_TRIAL_W'(MS_PER_S);

	logic                   busy_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [DIV_NUM_W-1:0]   num_q;
	logic [DIV_REM_W-1:0]   rem_q;
	logic [DIV_NUM_W-1:0]   num_n;
	logic [DIV_REM_W-1:0]   rem_n;

	// One radix-16 digit: four restoring compare-subtract steps
	always_comb begin
		logic [DIV_TRIAL_W-1:0] trial;
		rem_n = rem_q;
		num_n = num_q;
		for (int k = 0; k < DIV_DIGIT_W; k++) begin
			trial = {rem_n, num_n[DIV_NUM_W-1]};
			num_n = {num_n[DIV_NUM_W-2:0], 1'b0};
			if (trial >= DIVISOR) begin
				rem_n    = DIV_REM_W'(trial - DIVISOR);
				num_n[0] = 1'b1;
			end else begin
				rem_n = trial[DIV_REM_W-1:0];
			end
		end
	end

	// Sequence the digits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			if (cnt_q == CNT_LAST) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	// Shift dividend out and quotient in
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= DIV_NUM_W'(dividend);
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= num_n;
			rem_q <= rem_n;
		end
	end

	assign done     = busy_q && (cnt_q == CNT_LAST);
	assign quotient = num_q;

endmodule

// ===== rtl/core/psll_datapath.sv =====
// Datapath: configuration registers, source table, scan, update and result register.
// Depends on psll_pkg and instantiates psll_div.
`timescale 1ns / 1ps

module psll_datapath #(
	parameter int TABLE_ENTRIES = psll_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  psll_pkg::psll_cmd_t              cmd,
	output psll_pkg::psll_status_t           status,
	input  logic                             cfg_we,
	input  logic [psll_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [psll_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic [psll_pkg::ADDR_W-1:0]      in_source_ip,
	input  logic [psll_pkg::TIME_W-1:0]      in_now_ms,
	input  logic                             in_nonce_present,
	input  logic                             in_attempt_ok,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [psll_pkg::VERDICT_W-1:0]   out_verdict,
	output logic [psll_pkg::WAIT_W-1:0]      out_wait_seconds
);
	import psll_pkg::*;

	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_ENTRIES - 1);

	// Configuration
	logic               auth_en_q;
	logic [COUNT_W-1:0] max_fails_q;
	logic [TIME_W-1:0]  lock_ms_q;

	// Captured attempt
	logic               auth_q;
	logic [ADDR_W-1:0]  ip_q;
	logic [TIME_W-1:0]  now_q;
	logic               nonce_q;
	logic               ok_q;

	// Table storage
	entry_t             entry_mem_q [TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0] valid_q;
	logic               wr_en;
	entry_t             wr_entry;

	// Scan pipeline
	logic [IDX_W-1:0]   scan_idx_q;
	entry_t             rd_s1;
	logic               rd_valid_s1;
	logic [IDX_W-1:0]   rd_idx_s1;
	logic               rd_live_s1;
	entry_t             rd_entry;

	// Scan results
	logic               found_q;
	logic [IDX_W-1:0]   match_idx_q;
	entry_t             match_ent_q;
	logic               free_found_q;
	logic [IDX_W-1:0]   free_idx_q;
	logic [IDX_W-1:0]   oldest_idx_q;
	logic [TIME_W-1:0]  oldest_last_q;

	// Selected entry and decisions
	logic [IDX_W-1:0]   sel_idx_q;
	entry_t             cur_q;
	logic               locked_q;
	logic               limit_hit_q;
	logic [DIV_IN_W-1:0] div_operand_q;

	// Update logic
	logic               locked;
	logic [COUNT_W-1:0] base_cnt;
	logic [COUNT_W-1:0] fail_cnt;
	logic               limit_hit;
	logic [TIME_W-1:0]  lock_sum;
	logic [TIME_W-1:0]  lock_new;
	logic [DIV_IN_W-1:0] div_operand;

	// Divider and result
	logic                 div_done;
	logic [DIV_NUM_W-1:0] quotient;
	logic [WAIT_W-1:0]    wait_sat;
	logic                 out_valid_q;
	verdict_t             out_verdict_q;
	logic [WAIT_W-1:0]    out_wait_q;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			auth_en_q   <= 1'b0;
			max_fails_q <= MAX_FAILS_RESET;
			lock_ms_q   <= LOCK_MS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_AUTH_ENABLED: auth_en_q   <= cfg_data[0];
				REG_MAX_FAILS:    max_fails_q <= cfg_data[COUNT_W-1:0];
				REG_LOCK_MS:      lock_ms_q   <= cfg_data[TIME_W-1:0];
				default: ;
			endcase
		end
	end

	// Capture the attempt word
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			auth_q  <= auth_en_q;
			ip_q    <= in_source_ip;
			now_q   <= in_now_ms;
			nonce_q <= in_nonce_present;
			ok_q    <= in_attempt_ok;
		end
	end

	// Table memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_mem_q[sel_idx_q] <= wr_entry;
		end
		if (cmd.scan) begin
			rd_s1 <= entry_mem_q[scan_idx_q];
		end
	end

	// Entry valid bits: an entry never written reads as all zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[sel_idx_q] <= 1'b1;
		end
	end

	// Scan address and read pipeline flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q <= '0;
			rd_live_s1 <= 1'b0;
		end else begin
			rd_live_s1 <= cmd.scan;
			if (cmd.load) begin
				scan_idx_q <= '0;
			end else if (cmd.scan && (scan_idx_q != IDX_LAST)) begin
				scan_idx_q <= scan_idx_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan) begin
			rd_valid_s1 <= valid_q[scan_idx_q];
			rd_idx_s1   <= scan_idx_q;
		end
	end

	assign rd_entry = rd_valid_s1 ? rd_s1 : '0;

	// Track first match, first free entry and oldest last-fail
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
		end else if (cmd.load) begin
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
		end else if (rd_live_s1) begin
			if (!found_q && (rd_entry.addr == ip_q)) begin
				found_q <= 1'b1;
			end
			if (!free_found_q && (rd_entry.addr == '0)) begin
				free_found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_live_s1) begin
			if (!found_q && (rd_entry.addr == ip_q)) begin
				match_idx_q <= rd_idx_s1;
				match_ent_q <= rd_entry;
			end
			if (!free_found_q && (rd_entry.addr == '0)) begin
				free_idx_q <= rd_idx_s1;
			end
			if ((rd_idx_s1 == '0) || (rd_entry.last_fail < oldest_last_q)) begin
				oldest_idx_q  <= rd_idx_s1;
				oldest_last_q <= rd_entry.last_fail;
			end
		end
	end

	// Choose the entry; a fresh entry starts clear with last-fail at now
	always_ff @(posedge clk) begin
		if (cmd.decide) begin
			if (found_q) begin
				sel_idx_q <= match_idx_q;
				cur_q     <= match_ent_q;
			end else begin
				sel_idx_q <= free_found_q ? free_idx_q : oldest_idx_q;
				cur_q     <= '{addr: ip_q, fail_count: '0, lock_until: '0,
					last_fail: now_q};
			end
		end
	end

	// Lock check, expiry, failure count and new lock end
	always_comb begin
		locked    = (cur_q.lock_until != '0) && (now_q < cur_q.lock_until);
		base_cnt  = (cur_q.lock_until != '0) ? '0 : cur_q.fail_count;
		fail_cnt  = base_cnt + COUNT_W'(1);
		limit_hit = nonce_q && !ok_q && (fail_cnt >= max_fails_q);
		lock_sum  = now_q + lock_ms_q;
		lock_new  = (lock_sum == '0) ? TIME_W'(1) : lock_sum;

		wr_entry = cur_q;
		if (!locked) begin
			wr_entry.fail_count = base_cnt;
			wr_entry.lock_until = '0;
			if (nonce_q) begin
				if (!ok_q) begin
					wr_entry.last_fail = now_q;
					if (limit_hit) begin
						wr_entry.fail_count = '0;
						wr_entry.lock_until = lock_new;
					end else begin
						wr_entry.fail_count = fail_cnt;
					end
				end else begin
					wr_entry.fail_count = '0;
				end
			end
		end

		if (locked) begin
			div_operand = {1'b0, cur_q.lock_until - now_q} + DIV_IN_W'(MS_ROUND_UP);
		end else begin
			div_operand = {1'b0, lock_ms_q};
		end
	end

	assign wr_en = cmd.update;

	// Hold the decisions for the result
	always_ff @(posedge clk) begin
		if (cmd.update) begin
			locked_q      <= locked;
			limit_hit_q   <= limit_hit && !locked;
			div_operand_q <= div_operand;
		end
	end

	psll_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_operand_q),
		.done     (div_done),
		.quotient (quotient)
	);

	assign wait_sat = (quotient > DIV_NUM_W'(WAIT_MAX)) ? WAIT_MAX : quotient[WAIT_W-1:0];

	// Result register: holds a word while the next attempt is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			if (!auth_q) begin
				out_verdict_q <= VERDICT_UNCONFIGURED;
				out_wait_q    <= '0;
			end else if (locked_q) begin
				out_verdict_q <= VERDICT_LOCKED;
				out_wait_q    <= wait_sat;
			end else if (!ok_q) begin
				out_verdict_q <= VERDICT_FAILED;
				out_wait_q    <= limit_hit_q ? wait_sat : '0;
			end else begin
				out_verdict_q <= VERDICT_ACCEPTED;
				out_wait_q    <= '0;
			end
		end
	end

	assign out_valid        = out_valid_q;
	assign out_verdict      = out_verdict_q;
	assign out_wait_seconds = out_wait_q;

	assign status.auth_en     = auth_en_q;
	assign status.scan_last   = (scan_idx_q == IDX_LAST);
	assign status.emit_needed = locked_q || nonce_q;
	assign status.div_done    = div_done;
	assign status.out_free    = !out_valid_q || out_ready;

endmodule

// ===== rtl/core/psll_ctrl.sv =====
// Controller state machine: sequences capture, table scan, update, divide and result.
// Depends on psll_pkg for the state, command and status types.
`timescale 1ns / 1ps

module psll_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  psll_pkg::psll_status_t status,
	output psll_pkg::psll_cmd_t    cmd
);
	import psll_pkg::*;

	state_t state_q;
	state_t state_n;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// Next state and commands
	always_comb begin
		state_n  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_n  = status.auth_en ? ST_SCAN : ST_RESULT;
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (status.scan_last) begin
					state_n = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_n = ST_DECIDE;
			end
			ST_DECIDE: begin
				cmd.decide = 1'b1;
				state_n    = ST_UPDATE;
			end
			ST_UPDATE: begin
				cmd.update = 1'b1;
				state_n    = ST_DIVGO;
			end
			ST_DIVGO: begin
				if (status.emit_needed) begin
					cmd.div_start = 1'b1;
					state_n       = ST_DIV;
				end else begin
					state_n = ST_IDLE;
				end
			end
			ST_DIV: begin
				if (status.div_done) begin
					state_n = ST_RESULT;
				end
			end
			ST_RESULT: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					state_n  = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/core/per_source_login_lockout.sv =====
// Top level of the per-source login lockout table: controller plus datapath.
// Depends on psll_pkg, psll_req_if, psll_rsp_if, psll_ctrl and psll_datapath.
`timescale 1ns / 1ps

// Each attempt word is handled on its own. With authentication enabled the block scans the
// table one entry per cycle through a single registered read port, picks and rewrites the
// entry, then converts milliseconds to seconds in a radix-16 divider. An attempt that
// yields a verdict puts its result word on the output once the divide is done and the
// output register is free. One without a nonce and without a lock yields nothing, and the
// input is ready again after the update. With authentication disabled the block goes from
// capture straight to the result, with no scan or divide. The result sits in an output
// register, so the next attempt is taken while it waits. The table reads as empty after
// reset through per-entry valid bits, with no clearing pass.
module per_source_login_lockout #(
	parameter int TABLE_ENTRIES = psll_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	psll_req_if.sink                         req,
	psll_rsp_if.source                       rsp,
	input  logic                             cfg_we,
	input  logic [psll_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [psll_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import psll_pkg::*;

	psll_cmd_t    cmd;
	psll_status_t status;

	psll_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.status   (status),
		.cmd      (cmd)
	);

	psll_datapath #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.status           (status),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_source_ip     (req.source_ip),
		.in_now_ms        (req.now_ms),
		.in_nonce_present (req.nonce_present),
		.in_attempt_ok    (req.attempt_ok),
		.out_valid        (rsp.valid),
		.out_ready        (rsp.ready),
		.out_verdict      (rsp.verdict),
		.out_wait_seconds (rsp.wait_seconds)
	);

endmodule

// ===== rtl/core/psll_checker.sv =====
// Port-level checks of the login lockout block, bound to the top level.
// Depends on psll_pkg for verdict codes and the wait limit.
`timescale 1ns / 1ps

module psll_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           req_valid,
	input logic                           req_ready,
	input logic                           rsp_valid,
	input logic                           rsp_ready,
	input logic [psll_pkg::VERDICT_W-1:0] rsp_verdict,
	input logic [psll_pkg::WAIT_W-1:0]    rsp_wait_seconds
);
	import psll_pkg::*;

	// A stalled result word holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_verdict)
			&& $stable(rsp_wait_seconds))
		else $error("result word changed while stalled");

	// One attempt at a time: no new word right after one is taken
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("attempt taken while the previous one is in progress");

	// Accepted and unconfigured verdicts carry no wait
	a_no_wait: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_verdict == VERDICT_ACCEPTED || rsp_verdict == VERDICT_UNCONFIGURED)
			|-> rsp_wait_seconds == '0)
		else $error("wait given with a verdict that has none");

	// A lockout always asks for at least one second
	a_locked_wait: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_verdict == VERDICT_LOCKED) |-> rsp_wait_seconds != '0)
		else $error("locked verdict with zero wait");

	// Wait stays within the saturation limit
	a_wait_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_wait_seconds <= WAIT_MAX)
		else $error("wait beyond saturation limit");

endmodule

bind per_source_login_lockout psll_checker u_psll_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.req_valid        (req.valid),
	.req_ready        (req.ready),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_verdict      (rsp.verdict),
	.rsp_wait_seconds (rsp.wait_seconds)
);
